@@ rtl/pcvt_pkg.sv @@
package pcvt_pkg;

	localparam int Capacity  = 256;
	localparam int Ncpu      = 4;
	localparam int KeyBits   = 64;
	localparam int ValueBits = 64;
	localparam int IdxBits   = $clog2(Capacity);
	localparam int CpuBits   = 2;
	localparam int CntBits   = IdxBits + 1;
	localparam int SlotBits  = IdxBits + CpuBits;
	localparam int Slots     = Capacity * Ncpu;

	typedef enum logic [3:0] {
		REQ_LOOKUP     = 4'd0,
		REQ_UPDATE     = 4'd1,
		REQ_CLEAR      = 4'd2,
		REQ_NEXT       = 4'd3,
		REQ_LOOKUP_ALL = 4'd4,
		REQ_STAGE      = 4'd5,
		REQ_UPDATE_ALL = 4'd6,
		REQ_DELETE     = 4'd7,
		REQ_LOOKUP_DEL = 4'd8
	} req_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_EXISTS   = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADFLAGS = 3'd4
	} status_t;

	localparam logic [1:0] FLAG_ABSENT  = 2'd1;
	localparam logic [1:0] FLAG_PRESENT = 2'd2;
	localparam logic [1:0] FLAG_BAD     = 2'd3;

	typedef struct packed {
		logic [3:0]           req_type;
		logic [1:0]           cpu;
		logic                 key_given;
		logic [KeyBits-1:0]   key;
		logic [ValueBits-1:0] value;
		logic [1:0]           flags;
	} req_word_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ValueBits-1:0] value_out;
		logic [KeyBits-1:0]   found_key;
		logic [1:0]           slot_index;
		logic                 last;
	} rsp_word_t;

	// front to back: the request plus its known-invalid class
	typedef struct packed {
		req_word_t req;
		logic      known;
	} cmd_t;

endpackage

@@ rtl/pcvt_req_if.sv @@
interface pcvt_req_if;
	logic               valid;
	logic               ready;
	pcvt_pkg::req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pcvt_rsp_if.sv @@
interface pcvt_rsp_if;
	logic               valid;
	logic               ready;
	pcvt_pkg::rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pcvt_ram.sv @@
module pcvt_ram #(
	parameter int Width = 64,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/pcvt_front.sv @@
// Front: accepts words, classifies the request code and pushes them into a two-deep queue.
module pcvt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pcvt_req_if.sink             req,
	output logic                 cmd_valid,
	output pcvt_pkg::cmd_t       cmd,
	input  logic                 cmd_pop
);
	pcvt_pkg::cmd_t fifo_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	pcvt_pkg::cmd_t in_cmd;
	logic           push;

	// classify: unknown request codes are dropped by the back
	always_comb begin
		in_cmd.req   = req.data;
		in_cmd.known = (req.data.req_type <= 4'(pcvt_pkg::REQ_LOOKUP_DEL));
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

@@ rtl/pcvt_back.sv @@
// Back: sequencer that scans the table, reads and writes the slot RAMs, emits words.
module pcvt_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pcvt_pkg::CntBits-1:0]       limit,
	input  logic                               cmd_valid,
	input  pcvt_pkg::cmd_t                     cmd,
	output logic                               cmd_pop,
	pcvt_rsp_if.source                         rsp,
	output logic [pcvt_pkg::CntBits-1:0]       count
);
	localparam int IB = pcvt_pkg::IdxBits;
	localparam int CB = pcvt_pkg::CntBits;
	localparam int KB = pcvt_pkg::KeyBits;
	localparam int VB = pcvt_pkg::ValueBits;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_DEC   = 8'b0000_0100,
		S_NEXT  = 8'b0000_1000,
		S_NKRD  = 8'b0001_0000,
		S_WALL  = 8'b0010_0000,
		S_RD    = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	pcvt_pkg::req_word_t       r_q;
	logic [pcvt_pkg::Capacity-1:0] valid_q;
	logic [CB-1:0]             count_q;
	logic [VB-1:0]             staged_q [pcvt_pkg::Ncpu];
	logic [CB-1:0]             idx_q;      // scan pointer, one past the range at end
	logic                      found_q, free_q;
	logic [IB-1:0]             hit_q, free_idx_q, ent_q;
	logic [1:0]                j_q;        // slot counter for whole-entry work
	logic                      rd_pend_q;
	logic                      out_v_q;
	pcvt_pkg::rsp_word_t       out_q;
	pcvt_pkg::rsp_word_t       word_q;     // single word waiting for the output register
	logic                      emit_last_q;

	// key RAM: written on insert, read by the scan and by the next-key walk
	logic          k_we;
	logic [IB-1:0] k_waddr, k_raddr;
	logic [KB-1:0] k_rdata;
	// slot RAM
	logic                             v_we;
	logic [pcvt_pkg::SlotBits-1:0]    v_waddr, v_raddr;
	logic [VB-1:0]                    v_wdata, v_rdata;

	pcvt_ram #(.Width(KB), .Depth(pcvt_pkg::Capacity)) u_keys (
		.clk, .we(k_we), .waddr(k_waddr), .wdata(r_q.key), .raddr(k_raddr),
		.rdata(k_rdata));
	pcvt_ram #(.Width(VB), .Depth(pcvt_pkg::Slots)) u_vals (
		.clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr),
		.rdata(v_rdata));

	assign count     = count_q;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	logic out_free;
	assign out_free = !out_v_q || rsp.ready;

	// a word enters the output register this cycle
	logic emit;
	assign emit = out_free && ((state_q == S_OUT) || (state_q == S_RD && rd_pend_q));

	// scan address: entry under test in S_SCAN, entry whose key is returned in S_NKRD
	logic [IB-1:0] prev_idx;
	assign prev_idx = IB'(idx_q - CB'(1));
	assign k_raddr  = (state_q == S_NKRD) ? ent_q : idx_q[IB-1:0];
	assign k_waddr  = free_idx_q;

	logic dec_found, dec_full, alloc_ok;
	assign alloc_ok = free_q && (count_q < limit);

	always_comb begin
		cmd_pop = 1'b0;
		k_we    = 1'b0;
		v_we    = 1'b0;
		v_waddr = {ent_q, j_q};
		v_wdata = '0;
		v_raddr = {ent_q, j_q};
		dec_found = found_q;
		dec_full  = !alloc_ok;
		if (state_q == S_IDLE && cmd_valid) cmd_pop = 1'b1;
		if (state_q == S_WALL) begin
			v_we    = 1'b1;
			// clear writes zero; update-all writes the staged values; update writes the value into the caller's slot
			if (r_q.req_type == 4'(pcvt_pkg::REQ_UPDATE_ALL)) v_wdata = staged_q[j_q];
			else if (j_q == r_q.cpu && r_q.req_type != 4'(pcvt_pkg::REQ_CLEAR))
				v_wdata = r_q.value;
			if (!found_q && j_q == 2'd0) k_we = 1'b1;
		end
	end

	// response word helper
	function automatic pcvt_pkg::rsp_word_t mk(input logic [2:0] st);
		pcvt_pkg::rsp_word_t w;
		w = '0;
		w.status = st;
		w.last   = 1'b1;
		return w;
	endfunction

	logic hit_now;
	assign hit_now = valid_q[prev_idx] && (k_rdata == r_q.key);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) r_q <= cmd.req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			count_q     <= '0;
			for (int i = 0; i < pcvt_pkg::Ncpu; i++) staged_q[i] <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			hit_q       <= '0;
			free_idx_q  <= '0;
			ent_q       <= '0;
			j_q         <= '0;
			rd_pend_q   <= 1'b0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			word_q      <= '0;
			emit_last_q <= 1'b0;
		end else begin
			if (emit) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						rd_pend_q <= 1'b0;
						if (!cmd.known) state_q <= S_IDLE;
						else if (cmd.req.req_type == 4'(pcvt_pkg::REQ_STAGE)) begin
							staged_q[cmd.req.cpu] <= cmd.req.value;
							state_q <= S_OUT;
							word_q  <= mk(pcvt_pkg::ST_OK);
						end else state_q <= S_SCAN;
					end
				end
				// one entry per cycle: read key, compare next cycle
				S_SCAN: begin
					if (rd_pend_q) begin
						if (r_q.key_given && !found_q && hit_now) begin
							found_q <= 1'b1;
							hit_q   <= prev_idx;
						end
						if (!free_q && !valid_q[prev_idx]) begin
							free_q     <= 1'b1;
							free_idx_q <= prev_idx;
						end
					end
					if (idx_q == CB'(pcvt_pkg::Capacity)) begin
						rd_pend_q <= 1'b0;
						state_q   <= S_DEC;
					end else begin
						rd_pend_q <= 1'b1;
						idx_q     <= idx_q + CB'(1);
					end
				end
				S_DEC: begin
					j_q   <= '0;
					ent_q <= hit_q;
					state_q <= S_OUT;
					case (r_q.req_type)
						4'(pcvt_pkg::REQ_LOOKUP): begin
							if (!found_q) word_q <= mk(pcvt_pkg::ST_NOTFOUND);
							else begin
								j_q <= r_q.cpu;
								emit_last_q <= 1'b1;
								state_q <= S_RD;
							end
						end
						4'(pcvt_pkg::REQ_UPDATE): begin
							if (r_q.flags == pcvt_pkg::FLAG_BAD)
								word_q <= mk(pcvt_pkg::ST_BADFLAGS);
							else if (!r_q.key_given) word_q <= mk(pcvt_pkg::ST_NOTFOUND);
							else if (found_q) begin
								// single slot write done below via S_WALL with one pass
								j_q <= r_q.cpu;
								state_q <= S_WALL;
							end else if (dec_full) word_q <= mk(pcvt_pkg::ST_FULL);
							else begin
								ent_q <= free_idx_q;
								state_q <= S_WALL;
							end
						end
						4'(pcvt_pkg::REQ_CLEAR): begin
							word_q <= mk(pcvt_pkg::ST_OK);
							if (found_q) begin
								j_q <= r_q.cpu;
								state_q <= S_WALL;
							end
						end
						4'(pcvt_pkg::REQ_NEXT): begin
							idx_q   <= found_q ? CB'(hit_q) + CB'(1) : '0;
							state_q <= S_NEXT;
						end
						4'(pcvt_pkg::REQ_LOOKUP_ALL), 4'(pcvt_pkg::REQ_LOOKUP_DEL): begin
							if (!dec_found) word_q <= mk(pcvt_pkg::ST_NOTFOUND);
							else begin
								emit_last_q <= 1'b0;
								state_q <= S_RD;
							end
						end
						4'(pcvt_pkg::REQ_UPDATE_ALL): begin
							if (r_q.flags == pcvt_pkg::FLAG_BAD)
								word_q <= mk(pcvt_pkg::ST_BADFLAGS);
							else if (!r_q.key_given) word_q <= mk(pcvt_pkg::ST_NOTFOUND);
							else if (r_q.flags == pcvt_pkg::FLAG_ABSENT && found_q)
								word_q <= mk(pcvt_pkg::ST_EXISTS);
							else if (r_q.flags == pcvt_pkg::FLAG_PRESENT && !found_q)
								word_q <= mk(pcvt_pkg::ST_NOTFOUND);
							else if (!found_q && dec_full) word_q <= mk(pcvt_pkg::ST_FULL);
							else begin
								if (!found_q) ent_q <= free_idx_q;
								state_q <= S_WALL;
							end
						end
						4'(pcvt_pkg::REQ_DELETE): begin
							if (!found_q) word_q <= mk(pcvt_pkg::ST_NOTFOUND);
							else begin
								valid_q[hit_q] <= 1'b0;
								if (count_q != '0) count_q <= count_q - CB'(1);
								word_q <= mk(pcvt_pkg::ST_OK);
							end
						end
						default: word_q <= mk(pcvt_pkg::ST_NOTFOUND);
					endcase
				end
				// walk valid bits from idx_q for the next key
				S_NEXT: begin
					if (idx_q == CB'(pcvt_pkg::Capacity)) begin
						word_q  <= mk(pcvt_pkg::ST_NOTFOUND);
						state_q <= S_OUT;
					end else if (valid_q[idx_q[IB-1:0]]) begin
						ent_q   <= idx_q[IB-1:0];
						rd_pend_q <= 1'b0;
						state_q <= S_NKRD;
					end else idx_q <= idx_q + CB'(1);
				end
				S_NKRD: begin
					rd_pend_q <= 1'b1;
					if (rd_pend_q) begin
						word_q <= '{status: pcvt_pkg::ST_OK, value_out: '0,
							found_key: k_rdata, slot_index: '0, last: 1'b1};
						state_q <= S_OUT;
					end
				end
				// slot writes: one per cycle; whole-entry or fresh insert writes all
				S_WALL: begin
					if (!found_q && j_q == 2'd0) begin
						valid_q[ent_q] <= 1'b1;
						count_q <= count_q + CB'(1);
					end
					if (found_q && (r_q.req_type == 4'(pcvt_pkg::REQ_UPDATE) ||
							r_q.req_type == 4'(pcvt_pkg::REQ_CLEAR)) ||
							j_q == 2'(pcvt_pkg::Ncpu - 1)) begin
						word_q  <= mk(pcvt_pkg::ST_OK);
						state_q <= S_OUT;
					end else j_q <= j_q + 2'd1;
				end
				// slot reads with registered RAM: issue, then emit when output frees
				S_RD: begin
					if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (out_free) begin
						out_q.status     <= pcvt_pkg::ST_OK;
						out_q.value_out  <= v_rdata;
						out_q.found_key  <= '0;
						out_q.slot_index <= j_q;
						out_q.last       <= emit_last_q || (j_q == 2'(pcvt_pkg::Ncpu - 1));
						rd_pend_q <= 1'b0;
						if (emit_last_q || j_q == 2'(pcvt_pkg::Ncpu - 1)) begin
							if (r_q.req_type == 4'(pcvt_pkg::REQ_LOOKUP_DEL)) begin
								valid_q[ent_q] <= 1'b0;
								if (count_q != '0) count_q <= count_q - CB'(1);
							end
							state_q <= S_IDLE;
						end else j_q <= j_q + 2'd1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_q   <= word_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/per_cpu_keyed_value_table.sv @@
// Flow: a keyed request scans all 256 entries, one per cycle, before its first word leaves.
// Then slot writes follow, or slot reads that each wait for the output register, or a
// next-key walk over the valid bits that then reads the found entry's key.
// A stage request skips the scan; its word goes straight to the output register.
// Throughput: one request at a time in the back; the front queue holds two more.
// Reset (arst_n low) empties the table, zeroes staged values, sets the limit to 256.
module per_cpu_keyed_value_table (
	input  logic                             clk,
	input  logic                             arst_n,
	pcvt_req_if.sink                         req,
	pcvt_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [pcvt_pkg::CntBits-1:0]     cfg_wdata
);
	logic [pcvt_pkg::CntBits-1:0] max_q, count;
	logic                         cmd_valid, cmd_pop;
	pcvt_pkg::cmd_t               cmd;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= pcvt_pkg::CntBits'(pcvt_pkg::Capacity);
		else if (cfg_we) max_q <= cfg_wdata;
	end

	pcvt_front u_front (.clk, .arst_n, .req, .cmd_valid, .cmd, .cmd_pop);
	pcvt_back u_back (.clk, .arst_n, .limit(max_q), .cmd_valid, .cmd, .cmd_pop,
		.rsp, .count);

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count <= pcvt_pkg::CntBits'(pcvt_pkg::Capacity))
		else $error("entry count beyond capacity");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("pop from empty queue");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result word changed while stalled");
endmodule
